>>> sv/assert_macros.svh
// Assertion helpers for the RTL files; included by owbm_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, disabled while reset is asserted
`define OWBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true out of reset
`define OWBM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define OWBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define OWBM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/owbm_pkg.sv
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int TICK_W        = 16;
  localparam int CFG_IDX_W     = 3;

  // Command codes carried with each tick
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SLOT     = 3'd5;

  // Register defaults
  localparam logic [TICK_W-1:0] DEF_RESET_LOW    = 16'd3000;
  localparam logic [TICK_W-1:0] DEF_PRES_DELAY   = 16'd50;
  localparam logic [TICK_W-1:0] DEF_PRES_TIMEOUT = 16'd65535;
  localparam logic [TICK_W-1:0] DEF_RESET_RECOV  = 16'd150;
  localparam logic [TICK_W-1:0] DEF_WRITE_SLOT   = 16'd40;
  localparam logic [TICK_W-1:0] DEF_READ_SLOT    = 16'd50;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_DELAY = 4'd2,
    PH_RST_WATCH = 4'd3,
    PH_RST_RECOV = 4'd4,
    PH_WR_START  = 4'd5,
    PH_WR_SLOT   = 4'd6,
    PH_RD_START  = 4'd7,
    PH_RD_SAMPLE = 4'd8,
    PH_RD_HOLD   = 4'd9,
    PH_BIT_RECOV = 4'd10
  } phase_t;

  // One tick request
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       line;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // One result, drive_low in the lowest bit
  typedef struct packed {
    logic       presence;
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       drive;
  } res_t;

endpackage

>>> sv/owbm_front.sv
`timescale 1ns / 1ps

// Accepts tick requests, classifies them and holds them in a two-entry queue
module owbm_front
  import owbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output q_head_t    q_head,
  input  logic       q_pop
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             push;
  item_t            clean;

  assign in_ready = (count_r != (PTR_W + 1)'(DEPTH));
  assign push     = in_valid && in_ready;

  // Only a known command is kept; others collapse to a plain tick
  always_comb begin
    clean = in_item;
    case (in_item.op)
      OP_TICK, OP_RESET, OP_WRITE, OP_READ: clean.op = in_item.op;
      default: clean.op = OP_TICK;
    endcase
  end

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= clean;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = mem_r[rd_ptr_r];

endmodule

>>> sv/owbm_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Runs the bus sequencer one tick per request and registers each result
module owbm_back
  import owbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata,
  input  q_head_t              q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res
);

  logic [TICK_W-1:0] reset_low_r, pres_delay_r, pres_timeout_r;
  logic [TICK_W-1:0] reset_recov_r, write_slot_r, read_slot_r;

  phase_t                phase_r, phase_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic                  pres_r, pres_nxt;
  logic [7:0]            latch_r, latch_nxt;
  logic                  reading_r, reading_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_res_r;

  phase_t                ph;
  logic [TICK_W-1:0]     tc, tc_inc, len, tc_run;
  logic [BIT_IDX_W-1:0]  bi;
  logic [7:0]            sb;
  logic                  rd, to, step;
  logic                  drive_c, busy_c, done_c;
  item_t                 it;

  assign it    = q_head.item;
  assign step  = q_head.valid && (!out_valid_r || out_ready);
  assign q_pop = step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r    <= DEF_RESET_LOW;
      pres_delay_r   <= DEF_PRES_DELAY;
      pres_timeout_r <= DEF_PRES_TIMEOUT;
      reset_recov_r  <= DEF_RESET_RECOV;
      write_slot_r   <= DEF_WRITE_SLOT;
      read_slot_r    <= DEF_READ_SLOT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW:    reset_low_r    <= cfg_wdata;
        CFG_PRES_DELAY:   pres_delay_r   <= cfg_wdata;
        CFG_PRES_TIMEOUT: pres_timeout_r <= cfg_wdata;
        CFG_RESET_RECOV:  reset_recov_r  <= cfg_wdata;
        CFG_WRITE_SLOT:   write_slot_r   <= cfg_wdata;
        CFG_READ_SLOT:    read_slot_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: command start, phase timer and next state
  always_comb begin
    ph = phase_r;
    tc = tick_r;
    bi = bit_r;
    sb = shift_r;
    rd = reading_r;

    // A command on an idle tick starts its first phase on that same tick
    if ((phase_r == PH_IDLE) && (it.op != OP_TICK)) begin
      bi = '0;
      tc = '0;
      case (it.op)
        OP_RESET: ph = PH_RST_LOW;
        OP_WRITE: begin
          sb = it.data;
          rd = 1'b0;
          ph = PH_WR_START;
        end
        default: begin
          sb = '0;
          rd = 1'b1;
          ph = PH_RD_START;
        end
      endcase
    end

    busy_c = (ph != PH_IDLE);

    // Length of the current timed phase
    case (ph)
      PH_RST_LOW:   len = reset_low_r;
      PH_RST_DELAY: len = pres_delay_r;
      PH_RST_WATCH: len = pres_timeout_r;
      PH_RST_RECOV: len = reset_recov_r;
      PH_WR_SLOT:   len = write_slot_r;
      PH_RD_HOLD:   len = read_slot_r;
      default:      len = reset_low_r;
    endcase

    // Zero length acts as one tick, and a wrapped count ends the phase too
    tc_inc = tc + 16'd1;
    to     = (tc_inc >= len) || (tc_inc == '0);
    tc_run = to ? '0 : tc_inc;

    phase_nxt   = ph;
    tick_nxt    = tc;
    bit_nxt     = bi;
    shift_nxt   = sb;
    reading_nxt = rd;
    pres_nxt    = pres_r;
    latch_nxt   = latch_r;
    drive_c     = 1'b0;
    done_c      = 1'b0;

    case (ph)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive_c  = 1'b1;
        tick_nxt = tc_run;
        if (to) phase_nxt = PH_RST_DELAY;
      end
      PH_RST_DELAY: begin
        tick_nxt = tc_run;
        if (to) phase_nxt = PH_RST_WATCH;
      end
      PH_RST_WATCH: begin
        if (!it.line) begin
          pres_nxt  = 1'b1;
          tick_nxt  = '0;
          phase_nxt = PH_RST_RECOV;
        end else begin
          tick_nxt = tc_run;
          if (to) begin
            pres_nxt  = 1'b0;
            phase_nxt = PH_RST_RECOV;
          end
        end
      end
      PH_RST_RECOV: begin
        tick_nxt = tc_run;
        if (to) begin
          done_c    = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_WR_START: begin
        drive_c   = 1'b1;
        tick_nxt  = '0;
        phase_nxt = PH_WR_SLOT;
      end
      PH_WR_SLOT: begin
        drive_c  = ~sb[bi];
        tick_nxt = tc_run;
        if (to) phase_nxt = PH_BIT_RECOV;
      end
      PH_RD_START: begin
        drive_c   = 1'b1;
        tick_nxt  = '0;
        phase_nxt = PH_RD_SAMPLE;
      end
      PH_RD_SAMPLE: begin
        if (it.line) shift_nxt[bi] = 1'b1;
        tick_nxt  = '0;
        phase_nxt = PH_RD_HOLD;
      end
      PH_RD_HOLD: begin
        tick_nxt = tc_run;
        if (to) phase_nxt = PH_BIT_RECOV;
      end
      PH_BIT_RECOV: begin
        tick_nxt = '0;
        if (bi == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
          done_c    = 1'b1;
          if (rd) latch_nxt = sb;
          phase_nxt = PH_IDLE;
        end else begin
          bit_nxt   = bi + 1'b1;
          phase_nxt = rd ? PH_RD_START : PH_WR_START;
        end
      end
      default: begin
        tick_nxt  = '0;
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Sequencer state, advanced once per request taken from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      pres_r    <= 1'b0;
      latch_r   <= '0;
      reading_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      pres_r    <= pres_nxt;
      latch_r   <= latch_nxt;
      reading_r <= reading_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r.drive     <= drive_c;
      out_res_r.busy      <= busy_c;
      out_res_r.done      <= done_c;
      out_res_r.read_data <= latch_nxt;
      out_res_r.presence  <= pres_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Checks
  `OWBM_ASSERT(a_done_busy, clk, rst_n, out_valid_r |-> (!out_res_r.done || out_res_r.busy), "done without busy")
  `OWBM_ASSERT(a_drive_busy, clk, rst_n, out_valid_r |-> (!out_res_r.drive || out_res_r.busy), "line driven while idle")
  `OWBM_ASSERT(a_done_idle, clk, rst_n, (step && done_c) |=> (phase_r == PH_IDLE), "command end did not return to idle")
  `OWBM_ASSERT(a_hold_phase, clk, rst_n, !step |=> $stable(phase_r), "phase moved without a request")

endmodule

>>> sv/one_wire_bus_master_unit.sv
`timescale 1ns / 1ps
// Requests are queued in the front end; results are registered in the back end.
// Throughput: one request per cycle unless stalled, set by the one-tick sequencer step.
// A two-entry queue between front and back holds requests while the output stalls.
// Reset (rst_n low, synchronous): queue empty, sequencer idle, registers at defaults,
// read data and presence cleared.
module one_wire_bus_master_unit
  import owbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // in_tdata: data_byte[7:0], line_in[8], zero fill [15:9]
  input  logic [15:0]          in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]           in_tuser,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // out_tdata: drive_low[0], busy_res[1], done_res[2], read_data[10:3], presence[11],
  // zero fill [15:12]
  output logic [15:0]          out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  item_t   in_item;
  q_head_t q_head;
  logic    q_pop;
  res_t    res;

  assign in_item.op   = in_tuser;
  assign in_item.data = in_tdata[7:0];
  assign in_item.line = in_tdata[8];

  owbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  owbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {4'b0000, res};

endmodule
